FILE: hw/rtl/pcir_pkg.sv
// constants shared by the prime range counter
// no dependencies
`default_nettype none
package pcir_pkg;

  localparam int VALUE_W = 16;
  localparam int COUNT_W = VALUE_W + 1;
  localparam int SQ_W    = 2 * VALUE_W;
  localparam int BIT_W   = $clog2(VALUE_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;

endpackage
`default_nettype wire

FILE: hw/rtl/prime_count_in_range.sv
// prime counter over an inclusive range, trial division with a bit-serial remainder
// depends on pcir_pkg
// sequence: an empty range strobes its result in the cycle after start; otherwise each value
//   passes S_CHECK and S_NEXT, a prime a closing S_TEST too, each trial divisor d with d*d
//   <= value until a factor is found an S_TEST and S_DIV pass; strobe follows last value
// throughput: one item at a time, the next start is taken from the strobe cycle on
// the result shows on out_valid for one cycle and the receiver cannot stall
// reset: synchronous active-low rst_n returns the sequencer to idle, no strobe
`default_nettype none
module prime_count_in_range
  import pcir_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [VALUE_W-1:0] in_first_value,
  input  wire logic [VALUE_W-1:0] in_last_value,
  output logic                    out_valid,
  output logic [COUNT_W-1:0]      out_prime_count
);

  logic [2:0]         state_r, state_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [VALUE_W-1:0] hi_r, hi_nxt;
  logic [VALUE_W-1:0] div_r, div_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [VALUE_W-1:0] sh_r, sh_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [VALUE_W:0]   rem_shift;
  logic [VALUE_W:0]   rem_sub;

  assign rem_shift = {rem_r, sh_r[VALUE_W-1]};
  assign rem_sub   = rem_shift - {1'b0, div_r};

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    hi_nxt        = hi_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt   = in_first_value;
          hi_nxt    = in_last_value;
          count_nxt = '0;
          if (in_last_value < in_first_value) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        div_nxt = VALUE_W'(2);
        sq_nxt  = SQ_W'(4);
        if (val_r < VALUE_W'(2)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sq_r > {{(SQ_W-VALUE_W){1'b0}}, val_r}) begin
          count_nxt = count_r + COUNT_W'(1);
          state_nxt = S_NEXT;
        end else begin
          sh_nxt    = val_r;
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(VALUE_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring remainder step, one dividend bit per cycle
        if (rem_shift >= {1'b0, div_r}) begin
          rem_nxt = rem_sub[VALUE_W-1:0];
        end else begin
          rem_nxt = rem_shift[VALUE_W-1:0];
        end
        sh_nxt  = {sh_r[VALUE_W-2:0], 1'b0};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          if (rem_nxt == '0) begin
            state_nxt = S_NEXT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {{(SQ_W-VALUE_W-1){1'b0}}, div_r, 1'b1};
            div_nxt   = div_r + VALUE_W'(1);
            state_nxt = S_TEST;
          end
        end
      end
      S_NEXT: begin
        if (val_r == hi_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          val_nxt   = val_r + VALUE_W'(1);
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hi_r  <= hi_nxt;
    div_r <= div_nxt;
    sq_r  <= sq_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_count = count_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("accepted item neither started nor answered");

  a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (sq_r == SQ_W'({{VALUE_W{1'b0}}, div_r} * {{VALUE_W{1'b0}}, div_r})))
    else $error("divisor square out of step");

  a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r >= VALUE_W'(2)))
    else $error("trial divisor below two");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (val_r <= hi_r))
    else $error("value walked past range end");

endmodule
`default_nettype wire

FILE: tb/prime_count_in_range_tb.sv
// testbench for the prime range counter: a directed table, then random ranges in three idle phases
// every result is checked against the table count for given rows, else a trial-division count of the range
// depends on pcir_pkg and prime_count_in_range
`timescale 1ns / 1ps
module prime_count_in_range_tb;
  import pcir_pkg::*;

  localparam int TABLE_ROWS   = 22;
  localparam int RANDOM_ITEMS = 120;
  localparam int DRAIN_CYCLES = 50;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [VALUE_W-1:0] first;
    logic [VALUE_W-1:0] last;
    logic               given;
    logic [COUNT_W-1:0] count;
  } range_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] in_first_value = '0;
  logic [VALUE_W-1:0] in_last_value = '0;
  logic               busy;
  logic               out_valid;
  logic [COUNT_W-1:0] out_prime_count;

  logic [COUNT_W-1:0] expected_counts[$];
  logic [COUNT_W-1:0] due_count;
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 items_sent = 0;
  int                 empty_ranges = 0;
  longint             primes_total = 0;
  longint             cycles = 0;

  prime_count_in_range i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_first_value (in_first_value),
    .in_last_value  (in_last_value),
    .out_valid      (out_valid),
    .out_prime_count(out_prime_count)
  );

  always #1 clk = ~clk;

  function automatic logic [COUNT_W-1:0] primes_in_range(input logic [VALUE_W-1:0] lo,
                                                         input logic [VALUE_W-1:0] hi);
    int unsigned        v;
    int unsigned        d;
    bit                 is_prime;
    logic [COUNT_W-1:0] n;
    n = '0;
    if (hi >= lo) begin
      for (v = lo; v <= hi; v++) begin
        is_prime = (v >= 2);
        for (d = 2; is_prime && d * d <= v; d++) begin
          if (v % d == 0) is_prime = 1'b0;
        end
        if (is_prime) n++;
      end
    end
    return n;
  endfunction

  // given rows carry a count that can be read off directly
  function automatic range_row_t range_table(input int idx);
    case (idx)
      0:  return {16'd0,     16'd0,     1'b1, 17'd0};
      1:  return {16'd0,     16'd1,     1'b1, 17'd0};
      2:  return {16'd1,     16'd1,     1'b1, 17'd0};
      3:  return {16'd2,     16'd2,     1'b1, 17'd1};
      4:  return {16'd2,     16'd3,     1'b1, 17'd2};
      5:  return {16'd4,     16'd4,     1'b1, 17'd0};
      6:  return {16'd0,     16'd10,    1'b1, 17'd4};
      7:  return {16'd0,     16'd100,   1'b1, 17'd25};
      8:  return {16'd1,     16'd0,     1'b1, 17'd0};
      9:  return {16'd65535, 16'd0,     1'b1, 17'd0};
      10: return {16'd65535, 16'd65535, 1'b1, 17'd0};
      11: return {16'd65534, 16'd65533, 1'b1, 17'd0};
      12: return {16'd65521, 16'd65521, 1'b1, 17'd1};
      13: return {16'd65521, 16'd65535, 1'b1, 17'd1};
      14: return {16'd32749, 16'd32749, 1'b1, 17'd1};
      15: return {16'd32768, 16'd32768, 1'b1, 17'd0};
      16: return {16'd0,     16'd1000,  1'b1, 17'd168};
      17: return {16'd255,   16'd257,   1'b0, 17'd0};
      18: return {16'h5555,  16'h5570,  1'b0, 17'd0};
      19: return {16'haaaa,  16'haac0,  1'b0, 17'd0};
      20: return {16'd12345, 16'd12400, 1'b0, 17'd0};
      21: return {16'd65280, 16'd65300, 1'b0, 17'd0};
      default: return '0;
    endcase
  endfunction

  task automatic send_range(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                            input int idle_pct, input bit given,
                            input logic [COUNT_W-1:0] count);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_first_value <= lo;
    in_last_value  <= hi;
    do begin
      @(posedge clk);
    end while (busy);
    expected_counts.push_back(given ? count : primes_in_range(lo, hi));
    items_sent++;
    if (hi < lo) empty_ranges++;
  endtask

  // mostly short spans so that large primes stay affordable
  task automatic send_random_range(input int idle_pct);
    int lo;
    int hi;
    int span;
    if ($urandom_range(0, 7) == 0) begin
      hi = $urandom_range(0, 65534);
      lo = $urandom_range(hi + 1, 65535);
    end else begin
      if ($urandom_range(0, 1) == 1) lo = $urandom_range(0, 1023);
      else lo = $urandom_range(0, 65535);
      if (lo < 1024 && $urandom_range(0, 9) == 0) span = $urandom_range(16, 63);
      else span = $urandom_range(0, 15);
      hi = lo + span;
      if (hi > 65535) hi = 65535;
    end
    send_range(lo[VALUE_W-1:0], hi[VALUE_W-1:0], idle_pct, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_counts.size());
      $display("status: fail");
      $finish;
    end else if (rst_n && out_valid) begin
      results_seen++;
      if (expected_counts.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %0d", out_prime_count);
        mismatches++;
      end else begin
        due_count = expected_counts.pop_front();
        primes_total += out_prime_count;
        if (out_prime_count !== due_count) begin
          if (mismatches < 10) begin
            $display("result %0d: prime_count expected %0d, got %0d", results_seen,
                     due_count, out_prime_count);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    range_row_t row;
    int         pct;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int idx = 0; idx < TABLE_ROWS; idx++) begin
      row = range_table(idx);
      send_range(row.first, row.last, 0, row.given, row.count);
    end
    for (int phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 0 : (phase == 1) ? 74 : 6;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_random_range(pct);
    end
    start <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d ranges sent (%0d from the table, %0d empty), %0d results, %0d primes counted",
             items_sent, TABLE_ROWS, empty_ranges, results_seen, primes_total);
    $display("idle phases: none, sender 74 percent, sender 6 percent; %0d cycles, %0d mismatches",
             cycles, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
